// ===== sv/string_hash_index_unit_top_defines.svh =====
// ---------------------------------------------------------------------------
// String hash index unit - assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef STRING_HASH_INDEX_UNIT_TOP_DEFINES_SVH
`define STRING_HASH_INDEX_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define SHI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("string hash index unit: check failed");
// check that also runs through reset
`define SHI_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("string hash index unit: reset check failed");
`else
`define SHI_ASSERT(lbl, prop)
`define SHI_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== sv/shi_pkg.sv =====
// ---------------------------------------------------------------------------
// String hash index unit - package
// Moduli, seeds, register indexes and step unit control types.
// ---------------------------------------------------------------------------
package shi_pkg;

  // running hash width and defaults
  localparam int HASH_BITS        = 30;
  localparam int INDEX_BITS_DEF   = 24;
  localparam int MULT_BITS        = 6;
  localparam int CNT_BITS         = 5;

  localparam logic [HASH_BITS-1:0] POLY_MOD         = 30'd1000000009;
  localparam logic [HASH_BITS-1:0] DJB_MOD          = 30'd1000000007;
  localparam logic [HASH_BITS-1:0] DJB_INIT         = 30'd5381;
  localparam logic [HASH_BITS-1:0] TABLE_SIZE_RESET = 30'd20011;
  localparam logic [MULT_BITS-1:0] BASE_LOW         = 6'd31;
  localparam logic [MULT_BITS-1:0] BASE_HIGH        = 6'd37;
  localparam logic [MULT_BITS-1:0] DJB_MULT         = 6'd33;
  localparam logic [6:0]           LETTER_OFFSET    = 7'd96;

  // configuration register indexes
  localparam logic REG_BASE_SELECT = 1'b0;
  localparam logic REG_TABLE_SIZE  = 1'b1;

  // modulus used by the shared step unit
  typedef enum logic [1:0] {
    MOD_POLY,
    MOD_DJB,
    MOD_TABLE
  } mod_sel_t;

  typedef struct packed {
    logic     dbl;      // double the accumulator before adding
    mod_sel_t mod_sel;
  } step_op_t;

endpackage

// ===== sv/shi_mod_step.sv =====
// ---------------------------------------------------------------------------
// Modular step unit
// res = ((dbl ? 2*acc : acc) + addend) mod m, with acc, addend < m.
// ---------------------------------------------------------------------------
module shi_mod_step (
  input  shi_pkg::step_op_t                op,
  input  logic [shi_pkg::HASH_BITS-1:0]    acc,
  input  logic [shi_pkg::HASH_BITS-1:0]    addend,
  input  logic [shi_pkg::HASH_BITS-1:0]    table_mod,
  output logic [shi_pkg::HASH_BITS-1:0]    res
);

  logic [shi_pkg::HASH_BITS-1:0] m;
  logic [shi_pkg::HASH_BITS:0]   t0;
  logic [shi_pkg::HASH_BITS-1:0] t1;
  logic [shi_pkg::HASH_BITS:0]   u0;

  // modulus select
  always_comb begin
    unique case (op.mod_sel)
      shi_pkg::MOD_POLY:  m = shi_pkg::POLY_MOD;
      shi_pkg::MOD_DJB:   m = shi_pkg::DJB_MOD;
      shi_pkg::MOD_TABLE: m = table_mod;
      default:            m = table_mod;
    endcase
  end

  // double and fold once, then add and fold once
  always_comb begin
    t0  = op.dbl ? {acc, 1'b0} : {1'b0, acc};
    t1  = (t0 >= {1'b0, m}) ? shi_pkg::HASH_BITS'(t0 - {1'b0, m})
                            : t0[shi_pkg::HASH_BITS-1:0];
    u0  = {1'b0, t1} + {1'b0, addend};
    res = (u0 >= {1'b0, m}) ? shi_pkg::HASH_BITS'(u0 - {1'b0, m})
                            : u0[shi_pkg::HASH_BITS-1:0];
  end

endmodule

// ===== sv/shi_core.sv =====
// ---------------------------------------------------------------------------
// Hash sequencer
// Runs both running hashes and the final table reductions on one step unit.
// ---------------------------------------------------------------------------
module shi_core #(
  parameter int INDEX_BITS = shi_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [6:0]            in_letter,
  input  logic                  in_last,
  input  logic                  base_select,
  input  logic [INDEX_BITS-1:0] table_size,
  input  logic                  out_free,
  output logic                  res_valid,
  output logic [INDEX_BITS-1:0] res_primary,
  output logic [INDEX_BITS-1:0] res_auxiliary
);

  typedef enum logic [3:0] {
    S_IDLE, S_PMUL, S_PADD, S_BMUL, S_DMUL, S_DADD, S_RPOLY, S_RDJB, S_EMIT
  } state_t;

  localparam logic [shi_pkg::CNT_BITS-1:0] CNT_HASH =
    shi_pkg::CNT_BITS'(shi_pkg::HASH_BITS - 1);
  localparam logic [shi_pkg::CNT_BITS-1:0] CNT_MULT =
    shi_pkg::CNT_BITS'(shi_pkg::MULT_BITS - 1);
  localparam int PAD_BITS = shi_pkg::HASH_BITS - shi_pkg::MULT_BITS;

  state_t                          state;
  logic [shi_pkg::HASH_BITS-1:0]   poly_sum;
  logic [shi_pkg::HASH_BITS-1:0]   base_power;
  logic [shi_pkg::HASH_BITS-1:0]   djb_sum;
  logic [shi_pkg::HASH_BITS-1:0]   acc;
  logic [shi_pkg::HASH_BITS-1:0]   mult;     // multiplier / dividend bits, MSB first
  logic [shi_pkg::CNT_BITS-1:0]    cnt;
  logic [6:0]                      code;
  logic                            last;

  shi_pkg::step_op_t               op;
  logic [shi_pkg::HASH_BITS-1:0]   addend;
  logic [shi_pkg::HASH_BITS-1:0]   step_res;
  logic [shi_pkg::HASH_BITS-1:0]   table_mod;
  logic [shi_pkg::HASH_BITS-1:0]   weight;
  logic [shi_pkg::MULT_BITS-1:0]   base;
  logic                            ts_zero;

  assign table_mod = shi_pkg::HASH_BITS'(table_size);
  assign ts_zero   = (table_size == '0);
  assign base      = base_select ? shi_pkg::BASE_HIGH : shi_pkg::BASE_LOW;
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT) && out_free;

  // letter weight, negative codes folded to their residue
  always_comb begin
    if (in_letter >= shi_pkg::LETTER_OFFSET)
      weight = shi_pkg::HASH_BITS'(in_letter - shi_pkg::LETTER_OFFSET);
    else
      weight = shi_pkg::POLY_MOD - shi_pkg::HASH_BITS'(shi_pkg::LETTER_OFFSET - in_letter);
  end

  // step unit operands per state
  always_comb begin
    op.dbl     = 1'b1;
    op.mod_sel = shi_pkg::MOD_POLY;
    addend     = '0;
    unique case (state)
      S_PMUL: addend = mult[shi_pkg::HASH_BITS-1] ? base_power : '0;
      S_PADD: begin
        op.dbl = 1'b0;
        addend = poly_sum;
      end
      S_BMUL: addend = mult[shi_pkg::HASH_BITS-1] ? base_power : '0;
      S_DMUL: begin
        op.mod_sel = shi_pkg::MOD_DJB;
        addend     = mult[shi_pkg::HASH_BITS-1] ? djb_sum : '0;
      end
      S_DADD: begin
        op.dbl     = 1'b0;
        op.mod_sel = shi_pkg::MOD_DJB;
        addend     = shi_pkg::HASH_BITS'(code);
      end
      S_RPOLY, S_RDJB: begin
        op.mod_sel = shi_pkg::MOD_TABLE;
        addend     = shi_pkg::HASH_BITS'(mult[shi_pkg::HASH_BITS-1]);
      end
      default: addend = '0;
    endcase
  end

  shi_mod_step u_step (
    .op        (op),
    .acc       (acc),
    .addend    (addend),
    .table_mod (table_mod),
    .res       (step_res)
  );

  // sequencer and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      poly_sum   <= '0;
      base_power <= shi_pkg::HASH_BITS'(1);
      djb_sum    <= shi_pkg::DJB_INIT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            code  <= in_letter;
            last  <= in_last;
            mult  <= weight;
            acc   <= '0;
            cnt   <= CNT_HASH;
            state <= S_PMUL;
          end
        end
        // weight * base_power
        S_PMUL: begin
          acc  <= step_res;
          mult <= mult << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) state <= S_PADD;
        end
        S_PADD: begin
          poly_sum <= step_res;
          acc      <= '0;
          mult     <= {base, PAD_BITS'(0)};
          cnt      <= CNT_MULT;
          state    <= S_BMUL;
        end
        // base_power * base
        S_BMUL: begin
          if (cnt == '0) begin
            base_power <= step_res;
            acc        <= '0;
            mult       <= {shi_pkg::DJB_MULT, PAD_BITS'(0)};
            cnt        <= CNT_MULT;
            state      <= S_DMUL;
          end else begin
            acc  <= step_res;
            mult <= mult << 1;
            cnt  <= cnt - 1'b1;
          end
        end
        // djb_sum * 33
        S_DMUL: begin
          acc  <= step_res;
          mult <= mult << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) state <= S_DADD;
        end
        S_DADD: begin
          djb_sum <= step_res;
          acc     <= '0;
          mult    <= poly_sum;
          cnt     <= CNT_HASH;
          state   <= last ? S_RPOLY : S_IDLE;
        end
        // restoring remainder, one dividend bit a cycle
        S_RPOLY: begin
          if (cnt == '0) begin
            res_primary <= ts_zero ? '0 : step_res[INDEX_BITS-1:0];
            acc         <= '0;
            mult        <= djb_sum;
            cnt         <= CNT_HASH;
            state       <= S_RDJB;
          end else begin
            acc  <= step_res;
            mult <= mult << 1;
            cnt  <= cnt - 1'b1;
          end
        end
        S_RDJB: begin
          acc  <= step_res;
          mult <= mult << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            res_auxiliary <= ts_zero ? '0 : step_res[INDEX_BITS-1:0];
            state         <= S_EMIT;
          end
        end
        // hand over and start a fresh key
        S_EMIT: begin
          if (out_free) begin
            poly_sum   <= '0;
            base_power <= shi_pkg::HASH_BITS'(1);
            djb_sum    <= shi_pkg::DJB_INIT;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/string_hash_index_unit_top.sv =====
// ---------------------------------------------------------------------------
// String hash index unit - top level
// Polynomial rolling hash and djb2 over a key, reduced to table indexes.
// ---------------------------------------------------------------------------
// Usage:
//   Key letters enter on s_, one item per letter, s_tlast on the final one;
//   each key yields one m_ item: polynomial and djb2 hash modulo table_size.
//   One modular step unit does all arithmetic a bit a cycle. A letter runs a
//   30-bit weight multiply, an accumulate, 6-bit multiplies by the base and
//   by 33 and an add; s_tready stays low until it is done, so no new letter
//   is taken before then. A last letter adds two remainder passes; its
//   result is loaded on the edge at which s_tready returns.
//   The output register holds one result. While the receiver stalls the
//   next key's letters are still taken; only its result hand-over waits.
//   Reset (rst, synchronous) clears both hashes to their seeds, sets base 31
//   and table size 20011, and empties the output register. Registers are
//   written through cfg_we / cfg_addr / cfg_wdata; the user must do so only
//   while idle, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
`include "string_hash_index_unit_top_defines.svh"

module string_hash_index_unit_top #(
  parameter int INDEX_BITS = shi_pkg::INDEX_BITS_DEF,
  localparam int OUT_W = ((2 * INDEX_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [INDEX_BITS-1:0] cfg_wdata,
  // letter input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [6:0] letter
  input  logic                  s_tlast,   // last_letter
  // index output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata    // primary_index, auxiliary_index
);

  logic                  base_select;
  logic [INDEX_BITS-1:0] table_size;
  logic                  out_free;
  logic                  res_valid;
  logic [INDEX_BITS-1:0] res_primary;
  logic [INDEX_BITS-1:0] res_auxiliary;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= 1'b0;
      table_size  <= shi_pkg::TABLE_SIZE_RESET[INDEX_BITS-1:0];
    end else if (cfg_we) begin
      unique case (cfg_addr)
        shi_pkg::REG_BASE_SELECT: base_select <= cfg_wdata[0];
        shi_pkg::REG_TABLE_SIZE:  table_size  <= cfg_wdata;
        default:                  table_size  <= table_size;
      endcase
    end
  end

  shi_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_letter     (s_tdata[6:0]),
    .in_last       (s_tlast),
    .base_select   (base_select),
    .table_size    (table_size),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res_primary   (res_primary),
    .res_auxiliary (res_auxiliary)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_W'({res_auxiliary, res_primary});
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // checks
  `SHI_ASSERT_RST(a_rst_clear, rst |=> s_tready && !m_tvalid)
  `SHI_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready)
  `SHI_ASSERT(a_letter_latency, s_tvalid && s_tready && !s_tlast |-> ##45 s_tready)
  `SHI_ASSERT(a_emit_handover, res_valid |=> s_tready && m_tvalid)

endmodule

// ===== sim/string_hash_index_unit_checker.sv =====
// ---------------------------------------------------------------------------
// String hash index unit - checker
// Watches the configuration port and both item channels, keeps its own copy
// of the running polynomial and djb2 hashes, and compares every index item
// field by field against the oldest predicted pair.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module string_hash_index_unit_checker #(
  parameter int INDEX_BITS = shi_pkg::INDEX_BITS_DEF,
  localparam int OUT_W = ((2 * INDEX_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [INDEX_BITS-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [6:0] letter
  input  logic                  s_tlast,   // last_letter
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_W-1:0]      m_tdata,   // primary_index, auxiliary_index
  output int                    mismatches,
  output int                    outstanding
);
  import shi_pkg::*;

  typedef struct {
    logic [INDEX_BITS-1:0] primary;
    logic [INDEX_BITS-1:0] auxiliary;
  } index_pair_t;

  // predicted index pairs, oldest first
  index_pair_t index_queue[$];

  // running hashes and register copies
  logic [HASH_BITS-1:0]  poly_acc;
  logic [HASH_BITS-1:0]  power_acc;
  logic [HASH_BITS-1:0]  djb_acc;
  logic                  base_37;
  logic [INDEX_BITS-1:0] table_size;
  int                    mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void restart_key();
    poly_acc  = '0;
    power_acc = HASH_BITS'(1);
    djb_acc   = DJB_INIT;
  endfunction

  // final reduction; a zero table size yields zero
  function automatic logic [INDEX_BITS-1:0] fold_to_table(input logic [HASH_BITS-1:0] h);
    longint unsigned rem;
    if (table_size == '0) return '0;
    rem = longint'(h) % longint'(table_size);
    return rem[INDEX_BITS-1:0];
  endfunction

  // one letter through both hashes; a last letter closes the key
  function automatic void hash_letter(input logic [6:0] code, input logic last);
    longint unsigned weight;
    longint unsigned base;
    longint unsigned poly_m;
    longint unsigned djb_m;
    index_pair_t     pair;
    poly_m = longint'(POLY_MOD);
    djb_m  = longint'(DJB_MOD);
    base   = base_37 ? longint'(BASE_HIGH) : longint'(BASE_LOW);
    // codes under the offset give a negative weight, taken as its residue
    if (code >= LETTER_OFFSET) weight = longint'(code) - longint'(LETTER_OFFSET);
    else weight = poly_m - (longint'(LETTER_OFFSET) - longint'(code));
    poly_acc  = HASH_BITS'((longint'(poly_acc) + weight * longint'(power_acc)) % poly_m);
    power_acc = HASH_BITS'((longint'(power_acc) * base) % poly_m);
    djb_acc   = HASH_BITS'((longint'(djb_acc) * longint'(DJB_MULT) + longint'(code)) % djb_m);
    if (last) begin
      pair.primary   = fold_to_table(poly_acc);
      pair.auxiliary = fold_to_table(djb_acc);
      index_queue    = {index_queue, pair};
      restart_key();
    end
  endfunction

  always @(posedge clk) begin
    index_pair_t want;
    if (rst) begin
      restart_key();
      base_37    = 1'b0;
      table_size = TABLE_SIZE_RESET[INDEX_BITS-1:0];
      index_queue.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_addr == REG_BASE_SELECT) base_37 = cfg_wdata[0];
        else if (cfg_addr == REG_TABLE_SIZE) table_size = cfg_wdata;
      end
      // index items leaving the block
      if (m_tvalid && m_tready) begin
        if (index_queue.size() == 0) begin
          report_mismatch("index item with none expected, primary",
                          64'(m_tdata[INDEX_BITS-1:0]), 64'(0));
        end else begin
          want = index_queue.pop_front();
          if (m_tdata[INDEX_BITS-1:0] !== want.primary)
            report_mismatch("primary_index", 64'(m_tdata[INDEX_BITS-1:0]),
                            64'(want.primary));
          if (m_tdata[2*INDEX_BITS-1:INDEX_BITS] !== want.auxiliary)
            report_mismatch("auxiliary_index", 64'(m_tdata[2*INDEX_BITS-1:INDEX_BITS]),
                            64'(want.auxiliary));
        end
      end
      // letters entering the block
      if (s_tvalid && s_tready) hash_letter(s_tdata[6:0], s_tlast);
    end
    outstanding <= index_queue.size();
  end

endmodule

// ===== sim/string_hash_index_unit_top_tb.sv =====
// ---------------------------------------------------------------------------
// String hash index unit - testbench top
// Drives keys letter by letter in random bursts, stalls the index channel on
// its own pattern with one long hold-off, and changes base and table size
// between phases. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module string_hash_index_unit_top_tb;
  import shi_pkg::*;

  localparam int INDEX_BITS  = INDEX_BITS_DEF;
  localparam int OUT_W       = ((2 * INDEX_BITS + 7) / 8) * 8;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE      = 130;   // idle wait after the last index item is out
  localparam int LONG_HOLD   = 2500;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_addr = REG_BASE_SELECT;
  logic [INDEX_BITS-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [6:0] letter
  logic                  s_tlast = 1'b0; // last_letter
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;        // primary_index, auxiliary_index

  int   mismatches;
  int   outstanding;
  int   letters_sent = 0;
  int   burst_left = 1;
  logic long_hold_req = 1'b0;

  string_hash_index_unit_top #(.INDEX_BITS(INDEX_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  string_hash_index_unit_checker #(.INDEX_BITS(INDEX_BITS)) chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // register write, one cycle of enable
  task automatic write_reg(input logic addr, input logic [INDEX_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one letter until taken; bursts end in a random gap
  task automatic send_letter(input logic [6:0] code, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, code};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    letters_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 120)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
  endtask

  // random key; noisy keys carry any 7-bit code
  task automatic send_key(input bit noisy);
    int         len;
    logic [6:0] code;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      code = noisy ? 7'($urandom_range(0, 127)) : 7'($urandom_range(97, 122));
      send_letter(code, i == len - 1);
    end
  endtask

  // wait until every index item is out and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver: segments of always ready, random and sparse ready, one long hold
  initial begin : receiver
    int mode;
    int run_len;
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(20, 300);
      for (int k = 0; k < run_len; k++) begin
        @(posedge clk);
        if (long_hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          m_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (k % 7 == 0);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [INDEX_BITS-1:0] size_pick;
    int                    phase_start;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: shortest keys, edge codes, zero weight
    send_letter(7'd97, 1'b1);
    send_letter(7'd122, 1'b1);
    send_letter(7'd97, 1'b0);
    send_letter(7'd122, 1'b1);
    send_letter(7'd0, 1'b0);
    send_letter(7'd127, 1'b1);
    send_letter(7'd96, 1'b1);

    // base switched part way through a key
    send_letter(7'd104, 1'b0);
    send_letter(7'd101, 1'b0);
    settle();
    write_reg(REG_BASE_SELECT, INDEX_BITS'(1));
    send_letter(7'd108, 1'b1);

    // table size zero and one
    settle();
    write_reg(REG_TABLE_SIZE, INDEX_BITS'(0));
    send_letter(7'd113, 1'b1);
    send_letter(7'd95, 1'b1);
    settle();
    write_reg(REG_TABLE_SIZE, INDEX_BITS'(1));
    send_letter(7'd98, 1'b1);
    send_letter(7'd99, 1'b1);

    // table size two and the largest table size
    settle();
    write_reg(REG_TABLE_SIZE, INDEX_BITS'(2));
    send_letter(7'd109, 1'b1);
    settle();
    write_reg(REG_BASE_SELECT, INDEX_BITS'(0));
    write_reg(REG_TABLE_SIZE, {INDEX_BITS{1'b1}});
    for (int i = 0; i < 4; i++) send_letter(7'd122, i == 3);

    // random phases, new settings each time
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case ($urandom_range(0, 7))
        0:       size_pick = INDEX_BITS'(2);
        1:       size_pick = INDEX_BITS'(3);
        2:       size_pick = INDEX_BITS'(16777213);
        3:       size_pick = {INDEX_BITS{1'b1}};
        4:       size_pick = INDEX_BITS'($urandom_range(2, 65535));
        5:       size_pick = INDEX_BITS'($urandom);
        6:       size_pick = INDEX_BITS'($urandom_range(0, 1));
        default: size_pick = TABLE_SIZE_RESET[INDEX_BITS-1:0];
      endcase
      write_reg(REG_BASE_SELECT, INDEX_BITS'($urandom_range(0, 1)));
      write_reg(REG_TABLE_SIZE, size_pick);
      // fill the block against a stalled receiver
      if (phase == 1) long_hold_req <= 1'b1;
      phase_start = letters_sent;
      while (letters_sent - phase_start < PHASE_ITEMS)
        send_key($urandom_range(0, 9) == 0);
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== string_hash_index_unit_top.f =====
+incdir+sv
sv/shi_pkg.sv
sv/shi_mod_step.sv
sv/shi_core.sv
sv/string_hash_index_unit_top.sv
sim/string_hash_index_unit_checker.sv
sim/string_hash_index_unit_top_tb.sv
